### rtl/abrc_pkg.sv
// Shared types, codes and the CRC-32 byte update for the record check block.
`default_nettype none
package abrc_pkg;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] REC_MAGIC    = 32'h4653_4142;
   localparam int unsigned HDR_BYTES    = 12;
   localparam int unsigned CNT_W        = 17;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [15:0] PAGE_BYTES_RST = 16'd4096;

   // register select on the configuration port (word address bit)
   localparam logic REG_RECORD_LENGTH = 1'b0;
   localparam logic REG_PAGE_BYTES    = 1'b1;

   typedef enum logic [1:0] {
      FUNC_SAVE   = 2'd0,
      FUNC_PAGE_A = 2'd1,
      FUNC_PAGE_B = 2'd2,
      FUNC_DECIDE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_ARG_ERR = 2'd1,
      STAT_NO_DATA = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REPAIR_NONE = 2'd0,
      REPAIR_B    = 2'd1,
      REPAIR_A    = 2'd2
   } repair_type;

   typedef enum logic {
      KIND_SAVE   = 1'b0,
      KIND_DECIDE = 1'b1
   } kind_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  data_byte;
      logic        last;
      logic        read_failed;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      repair_type  repair_action;
      logic        source_page;
      logic [31:0] payload_crc;
   } result_type;

   // reflected CRC-32, one byte, bit-serial form unrolled
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/abrc_in_reg.sv
// Input register stage: holds one accepted byte item until the core consumes it.
`default_nettype none
module abrc_in_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire abrc_pkg::item_type  in_item,
   output logic                     out_valid,
   input  wire logic                out_take,
   output abrc_pkg::item_type       out_item
);

   logic               valid_ff, valid_in;
   abrc_pkg::item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = in_valid ? 1'b1 : (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ready ? in_valid : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule
`default_nettype wire

### rtl/abrc_core.sv
// Stream state, header parse, CRC update and A/B page decision.
`default_nettype none
module abrc_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire abrc_pkg::item_type   item,
   input  wire logic [15:0]          record_length,
   input  wire logic                 arg_error,
   output logic                      has_result,
   output abrc_pkg::result_type      result
);

   localparam int CW = abrc_pkg::CNT_W;

   logic [31:0]   crc_ff, crc_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   hdr_ff, hdr_in;
   logic          good_ff, good_in;
   logic [31:0]   stored_ff, stored_in;
   logic          a_valid_ff, a_valid_in;
   logic          b_valid_ff, b_valid_in;
   logic [31:0]   a_crc_ff, a_crc_in;
   logic [31:0]   b_crc_ff, b_crc_in;

   always_comb begin
      logic [CW-1:0] cnt;
      logic [31:0]   crc_upd;
      logic [31:0]   shifted;
      logic          ok;
      logic          err;

      crc_in     = crc_ff;
      count_in   = count_ff;
      hdr_in     = hdr_ff;
      good_in    = good_ff;
      stored_in  = stored_ff;
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      a_crc_in   = a_crc_ff;
      b_crc_in   = b_crc_ff;
      has_result = 1'b0;
      ok         = 1'b0;
      err        = 1'b0;

      result.kind          = abrc_pkg::KIND_SAVE;
      result.status        = abrc_pkg::STAT_OK;
      result.repair_action = abrc_pkg::REPAIR_NONE;
      result.source_page   = 1'b0;
      result.payload_crc   = '0;

      cnt     = (count_ff != abrc_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      crc_upd = abrc_pkg::crc_byte(crc_ff, item.data_byte);
      shifted = {24'd0, item.data_byte} << {count_ff[1:0], 3'b000};

      case (item.func)
         abrc_pkg::FUNC_DECIDE: begin
            has_result  = 1'b1;
            result.kind = abrc_pkg::KIND_DECIDE;
            if (arg_error) begin
               result.status = abrc_pkg::STAT_ARG_ERR;
            end else if (!a_valid_ff && !b_valid_ff) begin
               result.status = abrc_pkg::STAT_NO_DATA;
            end else if (a_valid_ff) begin
               result.payload_crc = a_crc_ff;
               if (!b_valid_ff || a_crc_ff != b_crc_ff) begin
                  result.repair_action = abrc_pkg::REPAIR_B;
               end
            end else begin
               result.source_page   = 1'b1;
               result.repair_action = abrc_pkg::REPAIR_A;
               result.payload_crc   = b_crc_ff;
            end
            a_valid_in = 1'b0;
            b_valid_in = 1'b0;
            crc_in     = abrc_pkg::CRC_ALL_ONES;
            count_in   = '0;
            hdr_in     = '0;
            good_in    = 1'b1;
            stored_in  = '0;
         end
         abrc_pkg::FUNC_SAVE: begin
            count_in = cnt;
            crc_in   = crc_upd;
            if (item.last) begin
               err        = arg_error || (cnt != {1'b0, record_length});
               has_result = 1'b1;
               result.status      = err ? abrc_pkg::STAT_ARG_ERR : abrc_pkg::STAT_OK;
               result.payload_crc = err ? 32'd0 : ~crc_upd;
               crc_in    = abrc_pkg::CRC_ALL_ONES;
               count_in  = '0;
               hdr_in    = '0;
               good_in   = 1'b1;
               stored_in = '0;
            end
         end
         default: begin
            // page A or page B byte
            count_in = cnt;
            if (item.read_failed) begin
               good_in = 1'b0;
            end
            if (count_ff < CW'(8)) begin
               hdr_in = hdr_ff | shifted;
               if (count_ff[2:0] == 3'd3) begin
                  if (hdr_in != abrc_pkg::REC_MAGIC) good_in = 1'b0;
                  hdr_in = '0;
               end else if (count_ff[2:0] == 3'd7) begin
                  if (hdr_in != {16'd0, record_length}) good_in = 1'b0;
                  hdr_in = '0;
               end
            end else if (count_ff < CW'(abrc_pkg::HDR_BYTES)) begin
               stored_in = stored_ff | shifted;
            end else begin
               crc_in = crc_upd;
            end
            if (item.last) begin
               ok = good_in &&
                    (cnt == ({1'b0, record_length} + CW'(abrc_pkg::HDR_BYTES))) &&
                    (~crc_in == stored_in);
               if (item.func == abrc_pkg::FUNC_PAGE_A) begin
                  a_valid_in = ok;
                  a_crc_in   = stored_in;
               end else begin
                  b_valid_in = ok;
                  b_crc_in   = stored_in;
               end
               crc_in    = abrc_pkg::CRC_ALL_ONES;
               count_in  = '0;
               hdr_in    = '0;
               good_in   = 1'b1;
               stored_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= abrc_pkg::CRC_ALL_ONES;
         count_ff   <= '0;
         hdr_ff     <= '0;
         good_ff    <= 1'b1;
         stored_ff  <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         a_crc_ff   <= '0;
         b_crc_ff   <= '0;
      end else if (fire) begin
         crc_ff     <= crc_in;
         count_ff   <= count_in;
         hdr_ff     <= hdr_in;
         good_ff    <= good_in;
         stored_ff  <= stored_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         a_crc_ff   <= a_crc_in;
         b_crc_ff   <= b_crc_in;
      end
   end

endmodule
`default_nettype wire

### rtl/ab_record_crc_check_select_top.sv
// Top level: A/B redundant record CRC-32 check with save CRC and page selection.
// A result passes the input register, which takes the req transfer of its byte, and
// the core logic into the result register behind rsp_tvalid; a held result stalls.
// Throughput: one byte item per cycle outside stalls, limited by the one-byte CRC-32
// update. Reset: synchronous, active high; stream state cleared, both pages invalid,
// record_length 0, page_bytes 4096. No clearing pass.
`default_nettype none
module ab_record_crc_check_select_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte item channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   input  wire logic [2:0]  req_tuser,   // [1:0] func, [2] read_failed
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [1:0] status, [3:2] repair_action,
                                         // [4] source_page, [36:5] payload_crc,
                                         // [39:37] zero
   output logic             rsp_tuser,   // [0] kind
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers. Register select is the word address bit;
   // the byte offset bits are not decoded.
   // ---------------------------------------------------------------
   logic [15:0] rec_len_ff;
   logic [16:0] page_bytes_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_len_ff    <= '0;
         page_bytes_ff <= {1'b0, abrc_pkg::PAGE_BYTES_RST};
      end else if (csr_wr) begin
         case (csr_paddr[2])
            abrc_pkg::REG_RECORD_LENGTH: rec_len_ff    <= csr_pwdata[15:0];
            abrc_pkg::REG_PAGE_BYTES:    page_bytes_ff <= csr_pwdata[16:0];
            default:                     rec_len_ff    <= rec_len_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         abrc_pkg::REG_RECORD_LENGTH: csr_prdata = {16'd0, rec_len_ff};
         abrc_pkg::REG_PAGE_BYTES:    csr_prdata = {15'd0, page_bytes_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // Record must be non-empty and fit after the header: length + 12 <= page size.
   // With a page of 12 bytes or less every non-zero length fails this too.
   logic [17:0] need_bytes;
   logic        arg_error;

   assign need_bytes = {2'b00, rec_len_ff} + 18'(abrc_pkg::HDR_BYTES);
   assign arg_error  = (rec_len_ff == '0) || (need_bytes > {1'b0, page_bytes_ff});

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   abrc_pkg::item_type req_item, s1_item;
   logic               s1_valid;
   logic               s1_take;

   assign req_item.func        = abrc_pkg::func_type'(req_tuser[1:0]);
   assign req_item.data_byte   = req_tdata;
   assign req_item.last        = req_tlast;
   assign req_item.read_failed = req_tuser[2];

   abrc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_take  (s1_take),
      .out_item  (s1_item)
   );

   // ---------------------------------------------------------------
   // Core: state update and result for the registered item
   // ---------------------------------------------------------------
   abrc_pkg::result_type core_res;
   logic                 core_has_res;
   logic                 rsp_valid_ff;
   abrc_pkg::result_type rsp_res_ff;

   // An item that gives no result always moves on; one that gives a result
   // needs the result register empty or emptying in this cycle.
   assign s1_take = s1_valid && (!core_has_res || !rsp_valid_ff || rsp_tready);

   abrc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_take),
      .item          (s1_item),
      .record_length (rec_len_ff),
      .arg_error     (arg_error),
      .has_result    (core_has_res),
      .result        (core_res)
   );

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic rsp_load;
   assign rsp_load = s1_take && core_has_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_res_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tdata  = {3'b000, rsp_res_ff.payload_crc, rsp_res_ff.source_page,
                        rsp_res_ff.repair_action, rsp_res_ff.status};

endmodule
`default_nettype wire

### tb/abrc_checker.sv
`timescale 1ns / 100ps
// Checker for the record CRC block: models the byte stream, predicts and compares results.
module abrc_checker
   import abrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   input  wire logic [2:0]  req_tuser,   // [1:0] func, [2] read_failed
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [1:0] status, [3:2] repair_action,
                                         // [4] source_page, [36:5] payload_crc
   input  wire logic        rsp_tuser,   // [0] kind
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int               mismatches,
   output int               open_results
);

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      repair_type  repair;
      logic        source;
      logic [31:0] crc;
   } verdict_type;

   verdict_type verdicts_due[$];

   // register copies
   logic [15:0] rec_len;
   logic [16:0] page_bytes;

   // stream state
   logic [31:0] crc_acc;
   logic [16:0] stream_bytes;
   logic [31:0] hdr_word;
   logic        hdr_ok;
   logic [31:0] crc_field;
   logic        a_ok;
   logic        b_ok;
   logic [31:0] a_crc;
   logic [31:0] b_crc;

   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

   // zero length, or no room for the record behind the header
   function automatic logic length_invalid();
      int unsigned room;
      room = (page_bytes > HDR_BYTES) ? page_bytes - HDR_BYTES : 0;
      return (rec_len == 16'd0) || (rec_len > room);
   endfunction

   task automatic restart_stream();
      crc_acc      = CRC_ALL_ONES;
      stream_bytes = '0;
      hdr_word     = '0;
      hdr_ok       = 1'b1;
      crc_field    = '0;
   endtask

   task automatic advance_record_state(input func_type f, input logic [7:0] b,
                                       input logic l, input logic rf);
      verdict_type v;
      logic [16:0] idx;
      logic        ok;
      v   = '0;
      idx = stream_bytes;
      if (f == FUNC_DECIDE) begin
         v.kind = KIND_DECIDE;
         if (length_invalid()) begin
            v.status = STAT_ARG_ERR;
         end else if (!a_ok && !b_ok) begin
            v.status = STAT_NO_DATA;
         end else if (a_ok) begin
            v.crc = a_crc;
            if (!b_ok || a_crc != b_crc) v.repair = REPAIR_B;
         end else begin
            v.source = 1'b1;
            v.repair = REPAIR_A;
            v.crc    = b_crc;
         end
         restart_stream();
         a_ok = 1'b0;
         b_ok = 1'b0;
         verdicts_due.push_back(v);
      end else begin
         if (stream_bytes != COUNT_MAX) stream_bytes = stream_bytes + 17'd1;
         if (f == FUNC_SAVE) begin
            crc_acc = crc32_byte(crc_acc, b);
            if (l) begin
               v.kind = KIND_SAVE;
               if (length_invalid() || stream_bytes != {1'b0, rec_len})
                  v.status = STAT_ARG_ERR;
               else
                  v.crc = ~crc_acc;
               verdicts_due.push_back(v);
               restart_stream();
            end
         end else begin
            if (rf) hdr_ok = 1'b0;
            if (idx < 8) begin
               hdr_word = hdr_word | ({24'd0, b} << (8 * idx[1:0]));
               if (idx == 3) begin
                  if (hdr_word != REC_MAGIC) hdr_ok = 1'b0;
                  hdr_word = '0;
               end else if (idx == 7) begin
                  if (hdr_word != {16'd0, rec_len}) hdr_ok = 1'b0;
                  hdr_word = '0;
               end
            end else if (idx < HDR_BYTES) begin
               crc_field = crc_field | ({24'd0, b} << (8 * idx[1:0]));
            end else begin
               crc_acc = crc32_byte(crc_acc, b);
            end
            if (l) begin
               ok = hdr_ok && (stream_bytes == HDR_BYTES + rec_len) &&
                    ((~crc_acc) == crc_field);
               if (f == FUNC_PAGE_A) begin
                  a_ok  = ok;
                  a_crc = crc_field;
               end else begin
                  b_ok  = ok;
                  b_crc = crc_field;
               end
               restart_stream();
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_verdict();
      verdict_type want;
      if (verdicts_due.size() == 0) begin
         $error("result transfer with nothing due: tdata %h tuser %b", rsp_tdata, rsp_tuser);
         mismatches++;
      end else begin
         want = verdicts_due.pop_front();
         compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
         compare_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
         compare_field("repair_action", 32'(want.repair), 32'(rsp_tdata[3:2]));
         compare_field("source_page", 32'(want.source), 32'(rsp_tdata[4]));
         compare_field("payload_crc", want.crc, rsp_tdata[36:5]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rec_len    = '0;
         page_bytes = 17'(PAGE_BYTES_RST);
         restart_stream();
         a_ok  = 1'b0;
         b_ok  = 1'b0;
         a_crc = '0;
         b_crc = '0;
         verdicts_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_verdict();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_PAGE_BYTES)
               page_bytes = csr_pwdata[16:0];
            else
               rec_len = csr_pwdata[15:0];
         end
         if (req_tvalid && req_tready)
            advance_record_state(func_type'(req_tuser[1:0]), req_tdata, req_tlast,
                                 req_tuser[2]);
      end
      open_results = verdicts_due.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the record CRC testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
   import abrc_pkg::*;

   localparam int CYCLE_LIMIT    = 4_000_000;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int RANDOM_RESULTS = 60;
   localparam int SETTLE_CYCLES  = 4;    // a page byte passes only the input register; slack

   // ways of spoiling a stored page
   typedef enum int {
      FLT_NONE,
      FLT_MAGIC,        // magic word wrong
      FLT_LENGTH,       // length field differs from record_length
      FLT_CRC,          // stored CRC wrong
      FLT_READ,         // one byte flagged as a failed read
      FLT_SHORT,        // one byte missing
      FLT_LONG,         // one byte too many
      FLT_MIX,          // one mid-page byte tagged as the other page
      FLT_LAST_OTHER,   // last byte tagged as the other page
      FLT_SAVE_MIX      // one mid-page byte tagged as a save byte
   } fault_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic [2:0]  req_tuser   = '0;
   wire         rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   wire  [39:0] rsp_tdata;
   wire         rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   int mismatches;
   int open_results;

   // stimulus bookkeeping
   int          burst_left   = 0;
   int          items_sent   = 0;
   int          results_sent = 0;
   int          cycles       = 0;
   int          stall_mode   = 0;
   int          stall_run    = 0;
   logic [15:0] cur_rec_len  = '0;
   logic [7:0]  payload_bytes[$];

   ab_record_crc_check_select_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   abrc_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .mismatches   (mismatches),
      .open_results (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang or a lost result ends up here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: runs of always-ready, random stalls and long stalls, each of
   // random length, so back-pressure hits every phase of a result.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(4, 60);
      end
      stall_run--;
      case (stall_mode)
         0, 1:    rsp_tready <= 1'b1;
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // One byte item, entered at a falling edge and left at the falling edge
   // after its transfer. tvalid stays high when the next item follows in the
   // same burst; a new burst may open with a gap.
   task automatic send_byte(input func_type f, input logic [7:0] b, input logic l,
                            input logic rf);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      req_tuser  <= {rf, f};
      items_sent++;
      if (f == FUNC_DECIDE || (f == FUNC_SAVE && l)) results_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write: setup cycle, then access until pready.
   task automatic write_reg(input logic sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Registers change only with the block idle: every result in, then a settling
   // wait as a page byte may still be in flight with nothing due.
   task automatic set_config(input logic [15:0] rec_len, input logic [16:0] page_bytes);
      req_tvalid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if ($urandom_range(0, 1)) begin
         write_reg(REG_RECORD_LENGTH, {16'd0, rec_len});
         write_reg(REG_PAGE_BYTES, {15'd0, page_bytes});
      end else begin
         write_reg(REG_PAGE_BYTES, {15'd0, page_bytes});
         write_reg(REG_RECORD_LENGTH, {16'd0, rec_len});
      end
      cur_rec_len = rec_len;
   endtask

   function automatic logic [31:0] payload_crc();
      logic [31:0] c;
      c = CRC_ALL_ONES;
      foreach (payload_bytes[i]) begin
         c = c ^ {24'd0, payload_bytes[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

   task automatic fill_payload();
      payload_bytes.delete();
      repeat (cur_rec_len) payload_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Page image: little-endian magic, length and CRC, then the payload.
   task automatic send_page(input func_type f, input fault_type fault);
      logic [7:0]  img[$];
      logic [31:0] magic;
      logic [31:0] lenw;
      logic [31:0] c;
      func_type    other;
      func_type    fb;
      int          n;
      int          pick;
      magic = REC_MAGIC;
      lenw  = {16'd0, cur_rec_len};
      c     = payload_crc();
      case (fault)
         FLT_MAGIC:  magic = magic ^ (32'd1 << $urandom_range(0, 31));
         FLT_LENGTH: lenw  = lenw ^ (32'd1 << $urandom_range(0, 31));
         FLT_CRC:    c     = c ^ (32'd1 << $urandom_range(0, 31));
         default: ;
      endcase
      for (int i = 0; i < 4; i++) img.push_back(magic[8*i +: 8]);
      for (int i = 0; i < 4; i++) img.push_back(lenw[8*i +: 8]);
      for (int i = 0; i < 4; i++) img.push_back(c[8*i +: 8]);
      foreach (payload_bytes[i]) img.push_back(payload_bytes[i]);
      if (fault == FLT_SHORT) void'(img.pop_back());
      if (fault == FLT_LONG) img.push_back(8'($urandom_range(0, 255)));
      other = (f == FUNC_PAGE_A) ? FUNC_PAGE_B : FUNC_PAGE_A;
      n     = img.size();
      pick  = $urandom_range(0, n - 2);
      for (int i = 0; i < n; i++) begin
         fb = f;
         if ((fault == FLT_MIX && i == pick) || (fault == FLT_LAST_OTHER && i == n - 1))
            fb = other;
         if (fault == FLT_SAVE_MIX && i == pick) fb = FUNC_SAVE;
         send_byte(fb, img[i], i == n - 1, fault == FLT_READ && i == pick);
      end
   endtask

   function automatic fault_type pick_fault();
      if ($urandom_range(0, 99) < 65) return FLT_NONE;
      return fault_type'($urandom_range(FLT_MAGIC, FLT_SAVE_MIX));
   endfunction

   task automatic save_stream(input int n);
      for (int i = 0; i < n; i++)
         send_byte(FUNC_SAVE, 8'($urandom_range(0, 255)), i == n - 1,
                   1'($urandom_range(0, 1)));
   endtask

   // mostly the exact record length, sometimes one off or arbitrary
   function automatic int save_count();
      int n;
      n = cur_rec_len;
      case ($urandom_range(0, 7))
         0:       n = n + 1;
         1:       n = (n > 1) ? n - 1 : n + 2;
         2:       n = $urandom_range(1, 24);
         default: ;
      endcase
      if (n == 0) n = $urandom_range(1, 4);
      return n;
   endfunction

   // A, then B, then the decision; now and then one or both pages are left out, and
   // B carries either A's payload or a fresh one.
   task automatic load_pair();
      fill_payload();
      if ($urandom_range(0, 6) != 0) send_page(FUNC_PAGE_A, pick_fault());
      if ($urandom_range(0, 1)) fill_payload();
      if ($urandom_range(0, 6) != 0) send_page(FUNC_PAGE_B, pick_fault());
      send_byte(FUNC_DECIDE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // arbitrary items: mixed funcs, stray lasts, decides out of turn
   task automatic noise_items();
      repeat ($urandom_range(1, 6))
         send_byte(func_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) < 7)
         send_byte(func_type'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), 1'b1,
                   1'($urandom_range(0, 1)));
   endtask

   // Settings for one random phase: mostly short records that fit, with
   // exact fits, the smallest page, the largest page and argument errors.
   task automatic random_config();
      logic [15:0] rl;
      logic [16:0] pb;
      rl = 16'($urandom_range(1, 20));
      case ($urandom_range(0, 9))
         0:       begin rl = 16'd0; pb = 17'($urandom_range(13, 65536)); end
         1:       pb = 17'd12 + rl;
         2:       pb = (rl > 16'd1) ? 17'd11 + rl : 17'd13;
         3:       begin rl = 16'($urandom_range(1, 2)); pb = 17'd13; end
         4:       pb = 17'h10000;
         default: pb = 17'($urandom_range(13, 65536));
      endcase
      set_config(rl, pb);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: record_length still zero after reset, so both the save and
      // the decision must flag an argument error.
      send_byte(FUNC_SAVE, 8'h00, 1'b1, 1'b0);
      send_byte(FUNC_DECIDE, 8'hFF, 1'b1, 1'b1);
      // Smallest page: one-byte record. Save ignores the read failure flag;
      // decision with no pages gives no valid data; a good A alone gives
      // source A with B to be rewritten.
      set_config(16'd1, 17'd13);
      send_byte(FUNC_SAVE, 8'hFF, 1'b1, 1'b1);
      send_byte(FUNC_DECIDE, 8'h00, 1'b0, 1'b0);
      fill_payload();
      send_page(FUNC_PAGE_A, FLT_NONE);
      send_byte(FUNC_DECIDE, 8'h00, 1'b0, 1'b0);
      // Largest settings: the record no longer fits behind the header.
      set_config(16'hFFFF, 17'h10000);
      send_byte(FUNC_DECIDE, 8'h00, 1'b0, 1'b0);
      send_byte(FUNC_SAVE, 8'h5A, 1'b1, 1'b0);
      // Largest record that still fits a 64 KiB page: no argument error, so
      // the decision reports no valid data.
      set_config(16'd65524, 17'h10000);
      send_byte(FUNC_DECIDE, 8'h00, 1'b0, 1'b0);

      // Random phases: mostly well-formed saves and page pairs.
      while (items_sent < RANDOM_ITEMS || results_sent < RANDOM_RESULTS) begin
         random_config();
         repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3:    save_stream(save_count());
               4, 5, 6, 7, 8: load_pair();
               default:       noise_items();
            endcase
         end
      end

      req_tvalid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/abrc_pkg.sv
rtl/abrc_in_reg.sv
rtl/abrc_core.sv
rtl/ab_record_crc_check_select_top.sv
tb/abrc_checker.sv
tb/tb_top.sv
